// File: hw/rtl/plbu_pkg.sv
// Shared types and constants for the price level book update unit.
`default_nettype none

package plbu_pkg;

   localparam int PRICE_W = 17;
   localparam int QTY_W   = 32;

   localparam logic OP_SNAPSHOT = 1'b0;
   localparam logic OP_DELTA    = 1'b1;

   localparam logic SIDE_YES = 1'b0;
   localparam logic SIDE_NO  = 1'b1;

   localparam logic STATUS_APPLIED   = 1'b0;
   localparam logic STATUS_OUT_RANGE = 1'b1;

   localparam logic [QTY_W-1:0] QTY_MAX = 32'h7FFF_FFFF;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_CALC
   } state_type;

   typedef struct packed {
      logic clear_en;
      logic load_req;
      logic rd_en;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
   } dp_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/plbu_req_if.sv
// Request channel interface: valid/ready handshake with the update fields.
`default_nettype none

interface plbu_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic        order_side;
   logic [16:0] price_level;
   logic [31:0] quantity;

   modport source (output valid, output opcode, output order_side,
                   output price_level, output quantity, input ready);
   modport sink   (input valid, input opcode, input order_side,
                   input price_level, input quantity, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/plbu_rsp_if.sv
// Response channel interface: valid/ready handshake with status and level quantity.
`default_nettype none

interface plbu_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [31:0] level_quantity;

   modport source (output valid, output status, output level_quantity, input ready);
   modport sink   (input valid, input status, input level_quantity, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/price_level_book_update_unit.sv
// Top level of the price level book update unit.
// An accepted request is registered, then read from both tables, then updated into the output reg.
// A new request is taken only after the previous one has passed the read and update controller states.
// A response may wait in the output register while the next request is taken.
// Reset: synchronous, active high; then a clearing sweep over all BOOK_LEVELS addresses zeroes
// both tables, with req ready low throughout.
`default_nettype none

module price_level_book_update_unit
   import plbu_pkg::*;
#(
   parameter int BOOK_LEVELS = 10000
) (
   input  wire logic  clock,
   input  wire logic  reset,
   plbu_req_if.sink   req_if,
   plbu_rsp_if.source rsp_if
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   plbu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   plbu_datapath #(.BOOK_LEVELS(BOOK_LEVELS)) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_opcode         (req_if.opcode),
      .req_order_side     (req_if.order_side),
      .req_price_level    (req_if.price_level),
      .req_quantity       (req_if.quantity),
      .rsp_status         (rsp_if.status),
      .rsp_level_quantity (rsp_if.level_quantity)
   );

endmodule

`default_nettype wire

// File: hw/rtl/plbu_ram.sv
// Generic single write, single read RAM with registered read data.
`default_nettype none

module plbu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 10000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/plbu_ctrl.sv
// Controller state machine: clearing sweep, request sequencing and response valid.
`default_nettype none

module plbu_ctrl
   import plbu_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
         end
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
         end
         ST_CALC: begin
            cmd.commit = rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_to_read: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_READ))
      else $error("accepted request did not start a read");

   a_read_to_calc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_CALC))
      else $error("read not followed by update");

   a_commit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed result not presented");

   a_no_commit_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> rsp_free)
      else $error("result overwritten while still pending");

endmodule

`default_nettype wire

// File: hw/rtl/plbu_datapath.sv
// Datapath: request register, both level tables, update arithmetic and response register.
`default_nettype none

module plbu_datapath
   import plbu_pkg::*;
#(
   parameter int BOOK_LEVELS = 10000
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ctrl_cmd_type       cmd,
   output dp_status_type           status,
   input  wire logic               req_opcode,
   input  wire logic               req_order_side,
   input  wire logic [PRICE_W-1:0] req_price_level,
   input  wire logic [QTY_W-1:0]   req_quantity,
   output logic                    rsp_status,
   output logic      [QTY_W-1:0]   rsp_level_quantity
);

   localparam int IDX_W = $clog2(BOOK_LEVELS);
   localparam logic [PRICE_W-1:0] LEVEL_LIMIT = PRICE_W'(BOOK_LEVELS);
   localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(BOOK_LEVELS - 1);

   logic               opcode_ff;
   logic               side_ff;
   logic [PRICE_W-1:0] level_ff;
   logic [QTY_W-1:0]   qty_ff;
   logic [IDX_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [QTY_W-1:0]   rsp_qty_ff, rsp_qty_in;

   logic               in_range;
   logic [IDX_W-1:0]   idx;
   logic [IDX_W-1:0]   wr_addr;
   logic [QTY_W-1:0]   wr_data;
   logic [QTY_W-1:0]   yes_rd, no_rd, old_qty;
   logic signed [QTY_W:0] sum;
   logic [QTY_W-1:0]   next_qty;
   logic               yes_wr, no_wr;

   assign in_range = !level_ff[PRICE_W-1] && (level_ff < LEVEL_LIMIT);
   assign idx      = level_ff[IDX_W-1:0];
   assign old_qty  = (side_ff == SIDE_NO) ? no_rd : yes_rd;
   assign sum      = $signed({old_qty[QTY_W-1], old_qty}) + $signed({qty_ff[QTY_W-1], qty_ff});

   always_comb begin
      if (opcode_ff == OP_SNAPSHOT) begin
         next_qty = qty_ff;
      end else if (sum[QTY_W]) begin
         next_qty = '0;
      end else if (sum[QTY_W-1]) begin
         next_qty = QTY_MAX;
      end else begin
         next_qty = sum[QTY_W-1:0];
      end
   end

   assign wr_addr = cmd.clear_en ? clr_cnt_ff : idx;
   assign wr_data = cmd.clear_en ? '0 : next_qty;
   assign yes_wr  = cmd.clear_en || (cmd.commit && in_range && side_ff == SIDE_YES);
   assign no_wr   = cmd.clear_en || (cmd.commit && in_range && side_ff == SIDE_NO);

   plbu_ram #(.WIDTH(QTY_W), .DEPTH(BOOK_LEVELS)) u_yes_ram (
      .clock   (clock),
      .wr_en   (yes_wr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx),
      .rd_data (yes_rd)
   );

   plbu_ram #(.WIDTH(QTY_W), .DEPTH(BOOK_LEVELS)) u_no_ram (
      .clock   (clock),
      .wr_en   (no_wr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx),
      .rd_data (no_rd)
   );

   assign clr_cnt_in        = cmd.clear_en ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
   assign status.clear_last = (clr_cnt_ff == LAST_IDX);

   // out-of-book levels report status and zero quantity
   assign rsp_status_in = cmd.commit ? (in_range ? STATUS_APPLIED : STATUS_OUT_RANGE)
                                     : rsp_status_ff;
   assign rsp_qty_in    = cmd.commit ? (in_range ? next_qty : '0) : rsp_qty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         opcode_ff <= req_opcode;
         side_ff   <= req_order_side;
         level_ff  <= req_price_level;
         qty_ff    <= req_quantity;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_qty_ff    <= rsp_qty_in;
   end

   assign rsp_status         = rsp_status_ff;
   assign rsp_level_quantity = rsp_qty_ff;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the price level book update unit: directed and random updates, scoreboard.

module tb
   import plbu_pkg::*;
();

   localparam int BOOK_LEVELS  = 10000;
   localparam int RANDOM_COUNT = 800;
   localparam int HOLD_AFTER   = 150;
   localparam int HOLD_CYCLES  = 300;
   localparam logic [QTY_W-1:0] QTY_MIN = 32'h8000_0000;

   typedef struct packed {
      logic               opcode;
      logic               order_side;
      logic [PRICE_W-1:0] price_level;
      logic [QTY_W-1:0]   quantity;
   } book_update_type;

   typedef struct packed {
      logic             status;
      logic [QTY_W-1:0] level_quantity;
   } level_result_type;

   logic clock;
   logic reset;

   plbu_req_if req_if();
   plbu_rsp_if rsp_if();

   price_level_book_update_unit #(.BOOK_LEVELS(BOOK_LEVELS)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   logic signed [QTY_W-1:0] yes_book [BOOK_LEVELS];
   logic signed [QTY_W-1:0] no_book  [BOOK_LEVELS];

   book_update_type  update_queue [$];
   level_result_type level_expect [$];
   book_update_type  offered;

   int   gap_left;
   int   stall_left;
   int   hold_left;
   logic hold_on;
   logic hold_done;
   int   updates_taken;
   int   results_seen;
   int   error_count;
   int   n_snapshot, n_delta, n_out_range, n_saturated, n_clamped;
   int   hot_levels [16];

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic level_result_type apply_update(book_update_type u);
      logic signed [PRICE_W-1:0] lvl;
      logic signed [QTY_W-1:0]   cur;
      longint                    sum;
      int                        idx;
      level_result_type          r;
      lvl = $signed(u.price_level);
      r.status = STATUS_APPLIED;
      r.level_quantity = '0;
      if (lvl < 0 || lvl >= BOOK_LEVELS) begin
         n_out_range++;
         r.status = STATUS_OUT_RANGE;
         return r;
      end
      idx = int'(lvl);
      cur = (u.order_side == SIDE_NO) ? no_book[idx] : yes_book[idx];
      if (u.opcode == OP_SNAPSHOT) begin
         n_snapshot++;
         sum = longint'($signed(u.quantity));
      end else begin
         n_delta++;
         sum = longint'(cur) + longint'($signed(u.quantity));
         if (sum < 0) begin
            sum = 0;
            n_clamped++;
         end else if (sum > longint'(QTY_MAX)) begin
            sum = longint'(QTY_MAX);
            n_saturated++;
         end
      end
      r.level_quantity = sum[QTY_W-1:0];
      if (u.order_side == SIDE_NO) no_book[idx] = r.level_quantity;
      else yes_book[idx] = r.level_quantity;
      return r;
   endfunction

   function automatic book_update_type make_update(logic op, logic side, int lvl,
                                                   logic [QTY_W-1:0] qty);
      book_update_type u;
      u.opcode      = op;
      u.order_side  = side;
      u.price_level = PRICE_W'(lvl);
      u.quantity    = qty;
      return u;
   endfunction

   function automatic int pick_level();
      int r;
      logic [31:0] w;
      r = $urandom_range(0, 99);
      w = $urandom;
      if (r < 70) return hot_levels[$urandom_range(0, 15)];
      if (r < 80) return $urandom_range(0, BOOK_LEVELS - 1);
      if (r < 90) return int'($signed(w[PRICE_W-1:0]));
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return BOOK_LEVELS - 1;
         2:       return BOOK_LEVELS;
         default: return -1;
      endcase
   endfunction

   function automatic logic [QTY_W-1:0] pick_quantity();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return QTY_W'($urandom_range(0, 10000) - 5000);
      if (r < 60) return QTY_W'($urandom_range(32'h7000_0000, 32'h7FFF_FFFF));
      if (r < 80) return QTY_W'($urandom);
      if (r < 90) begin
         case ($urandom_range(0, 3))
            0:       return QTY_MAX;
            1:       return QTY_MIN;
            2:       return '0;
            default: return '1;
         endcase
      end
      return QTY_MIN | QTY_W'($urandom_range(0, 32'h0FFF_FFFF));
   endfunction

   function automatic int pick_gap();
      int r;
      if (hold_on || (updates_taken / 100) % 3 == 1) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_stall();
      int r;
      if ((results_seen / 80) % 4 == 2) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            level_expect.push_back(apply_update(offered));
            updates_taken <= updates_taken + 1;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (update_queue.size() > 0) begin
               offered = update_queue.pop_front();
               req_if.valid       <= 1'b1;
               req_if.opcode      <= offered.opcode;
               req_if.order_side  <= offered.order_side;
               req_if.price_level <= offered.price_level;
               req_if.quantity    <= offered.quantity;
               gap_left = pick_gap();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin : rsp_check
      level_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen <= results_seen + 1;
            if (level_expect.size() == 0) begin
               $error("unexpected response: status %0d level_quantity %0d",
                      rsp_if.status, $signed(rsp_if.level_quantity));
               error_count++;
            end else begin
               want = level_expect.pop_front();
               if (rsp_if.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                  error_count++;
               end
               if (rsp_if.level_quantity !== want.level_quantity) begin
                  $error("level_quantity: expected %0d, got %0d",
                         $signed(want.level_quantity), $signed(rsp_if.level_quantity));
                  error_count++;
               end
            end
         end
         if (hold_on) begin
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            stall_left = pick_stall();
         end
      end
   end

   // long receiver hold-off to back the unit up
   always @(posedge clock) begin
      if (reset) begin
         hold_on   <= 1'b0;
         hold_done <= 1'b0;
         hold_left <= 0;
      end else if (hold_on) begin
         if (hold_left == 1) begin
            hold_on   <= 1'b0;
            hold_done <= 1'b1;
         end
         hold_left <= hold_left - 1;
      end else if (!hold_done && updates_taken >= HOLD_AFTER) begin
         hold_on   <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end
   end

   initial begin
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.opcode      = OP_SNAPSHOT;
      req_if.order_side  = SIDE_YES;
      req_if.price_level = '0;
      req_if.quantity    = '0;
      rsp_if.ready       = 1'b0;
      updates_taken = 0;
      results_seen  = 0;
      error_count   = 0;
      n_snapshot    = 0;
      n_delta       = 0;
      n_out_range   = 0;
      n_saturated   = 0;
      n_clamped     = 0;
      for (int i = 0; i < BOOK_LEVELS; i++) begin
         yes_book[i] = '0;
         no_book[i]  = '0;
      end
      hot_levels[0] = 0;
      hot_levels[1] = BOOK_LEVELS - 1;
      for (int i = 2; i < 16; i++) hot_levels[i] = $urandom_range(0, BOOK_LEVELS - 1);

      // saturation and clamping at the bottom and top levels
      update_queue.push_back(make_update(OP_SNAPSHOT, SIDE_YES, 0, QTY_MAX));
      update_queue.push_back(make_update(OP_DELTA, SIDE_YES, 0, 32'd1));
      update_queue.push_back(make_update(OP_DELTA, SIDE_YES, 0, QTY_MAX));
      update_queue.push_back(make_update(OP_DELTA, SIDE_YES, 0, QTY_MIN));
      update_queue.push_back(make_update(OP_SNAPSHOT, SIDE_NO, BOOK_LEVELS - 1, QTY_MIN));
      update_queue.push_back(make_update(OP_DELTA, SIDE_NO, BOOK_LEVELS - 1, '1));
      update_queue.push_back(make_update(OP_DELTA, SIDE_NO, BOOK_LEVELS - 1, QTY_MIN));
      update_queue.push_back(make_update(OP_SNAPSHOT, SIDE_YES, BOOK_LEVELS - 1, 32'd12345));
      // accumulation; neighbouring snapshot must leave level 5 alone
      update_queue.push_back(make_update(OP_DELTA, SIDE_YES, 5, 32'd100));
      update_queue.push_back(make_update(OP_DELTA, SIDE_YES, 5, 32'd50));
      update_queue.push_back(make_update(OP_SNAPSHOT, SIDE_YES, 6, 32'd7));
      update_queue.push_back(make_update(OP_DELTA, SIDE_YES, 5, 32'd0));
      update_queue.push_back(make_update(OP_SNAPSHOT, SIDE_NO, 5, -32'sd500));
      update_queue.push_back(make_update(OP_DELTA, SIDE_NO, 5, 32'd200));
      update_queue.push_back(make_update(OP_DELTA, SIDE_NO, 5, QTY_MAX));
      update_queue.push_back(make_update(OP_DELTA, SIDE_NO, 5, QTY_MAX));
      update_queue.push_back(make_update(OP_DELTA, SIDE_YES, 5, -32'sd150));
      // levels outside the book, then updates to in-book levels 1 and 0
      update_queue.push_back(make_update(OP_SNAPSHOT, SIDE_YES, BOOK_LEVELS, 32'd42));
      update_queue.push_back(make_update(OP_DELTA, SIDE_NO, -1, 32'd5));
      update_queue.push_back(make_update(OP_SNAPSHOT, SIDE_NO, 65535, '1));
      update_queue.push_back(make_update(OP_DELTA, SIDE_YES, -65536, QTY_MAX));
      update_queue.push_back(make_update(OP_DELTA, SIDE_NO, 1, 32'd42));
      update_queue.push_back(make_update(OP_SNAPSHOT, SIDE_YES, 0, '0));

      for (int i = 0; i < RANDOM_COUNT; i++) begin
         update_queue.push_back(make_update(
            ($urandom_range(0, 99) < 70) ? OP_DELTA : OP_SNAPSHOT,
            $urandom_range(0, 1) ? SIDE_NO : SIDE_YES,
            pick_level(), pick_quantity()));
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (update_queue.size() > 0 || req_if.valid) @(posedge clock);
      while (level_expect.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Covered %0d snapshots, %0d deltas, %0d out-of-book levels;",
               n_snapshot, n_delta, n_out_range);
      $display("%0d saturated, %0d clamped; checked %0d responses with a %0d-cycle hold.",
               n_saturated, n_clamped, results_seen, HOLD_CYCLES);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
